/* rtl/core/hostname_validator_macros.svh */
// Assertion macros shared by the hostname validator RTL.
`ifndef HOSTNAME_VALIDATOR_MACROS_SVH
`define HOSTNAME_VALIDATOR_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define HV_ASSERT_IMPLY(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("hostname_validator assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HV_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("hostname_validator assertion failed");

`else

`define HV_ASSERT_IMPLY(label, clock, resetn, ante, cons)
`define HV_ASSERT_NEXT(label, clock, resetn, ante, cons)

`endif

`endif

/* rtl/core/hv_pkg.sv */
// Shared types, codes and character helpers for the hostname validator.
`default_nettype none

package hv_pkg;

    // Character codes with a special role.
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;

    // Saturating counter widths: labels stop at 64, names at 256.
    localparam int LABEL_W = 7;
    localparam int TOTAL_W = 9;

    // Configuration register indexes.
    localparam logic REG_MAX_LABEL = 1'b0;
    localparam logic REG_MAX_NAME  = 1'b1;

    // Reset values of the limits.
    localparam logic [5:0] MAX_LABEL_RESET = 6'd63;
    localparam logic [7:0] MAX_NAME_RESET  = 8'd255;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_LABEL  = 2'd1,
        PH_IGNORE = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_BAD_START  = 3'd1,
        ERR_LABEL_LONG = 3'd2,
        ERR_HYPHEN_END = 3'd3,
        ERR_ALL_DIGITS = 3'd4,
        ERR_NAME_LONG  = 3'd5
    } err_code_t;

    // One input word.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_word_t;

    // One verdict as produced by the scanner.
    typedef struct packed {
        logic       valid;
        logic       ok;
        err_code_t  fail_code;
        logic [7:0] name_length;
        logic       stopped_at_char;
    } verdict_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    // Checks applied when a label ends: too long, then hyphen end, then all digits.
    function automatic err_code_t label_check(input logic [LABEL_W-1:0] len,
                                              input logic prev_regular,
                                              input logic only_digits,
                                              input logic [5:0] max_label);
        err_code_t e;
        if (len > {1'b0, max_label}) begin
            e = ERR_LABEL_LONG;
        end else if (!prev_regular) begin
            e = ERR_HYPHEN_END;
        end else if (only_digits) begin
            e = ERR_ALL_DIGITS;
        end else begin
            e = ERR_NONE;
        end
        return e;
    endfunction

    // Label checks, then the whole-name length check.
    function automatic err_code_t name_check(input logic [LABEL_W-1:0] len,
                                             input logic [TOTAL_W-1:0] total,
                                             input logic prev_regular,
                                             input logic only_digits,
                                             input logic [5:0] max_label,
                                             input logic [7:0] max_name);
        err_code_t e;
        e = label_check(len, prev_regular, only_digits, max_label);
        if ((e == ERR_NONE) && (total > {1'b0, max_name})) begin
            e = ERR_NAME_LONG;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/hv_cfg_regs.sv */
// APB register file holding the label and name length limits.
`default_nettype none

module hv_cfg_regs
    import hv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [5:0]  max_label_length,
    output logic [7:0]  max_name_length
);

    logic [5:0] max_label_reg;
    logic [7:0] max_name_reg;
    logic       wr_en;

    // A write lands in the access phase; the word index is address bit 2.
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_label_reg <= MAX_LABEL_RESET;
            max_name_reg  <= MAX_NAME_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_MAX_LABEL)
            begin
                max_label_reg <= pwdata[5:0];
            end
            else
            begin
                max_name_reg <= pwdata[7:0];
            end
        end
    end

    // Read data is the selected register, zero extended.
    always_comb
    begin
        if (paddr[2] == REG_MAX_NAME)
        begin
            prdata = {24'd0, max_name_reg};
        end
        else
        begin
            prdata = {26'd0, max_label_reg};
        end
    end

    assign max_label_length = max_label_reg;
    assign max_name_length  = max_name_reg;

endmodule

`default_nettype wire

/* rtl/core/hv_scan.sv */
// Hostname scanner: per-character state update and verdict logic.
`default_nettype none
`include "hostname_validator_macros.svh"

module hv_scan
    import hv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  char_word_t word,
    input  logic [5:0] max_label_length,
    input  logic [7:0] max_name_length,
    output verdict_t   verdict
);

    phase_t               phase_reg,  phase_next;
    logic [LABEL_W-1:0]   label_reg,  label_next;
    logic [TOTAL_W-1:0]   total_reg,  total_next;
    logic                 prev_reg,   prev_next;
    logic                 digits_reg, digits_next;

    // Tentative state after taking the character.
    phase_t               t_phase;
    logic [LABEL_W-1:0]   t_label;
    logic [TOTAL_W-1:0]   t_total;
    logic                 t_prev;
    logic                 t_digits;

    logic                 c_digit;
    logic                 c_alnum;
    logic                 ignoring;
    logic                 give;
    logic                 stop;
    err_code_t            err;
    err_code_t            cur_label_err;
    err_code_t            cur_name_err;

    assign c_digit       = is_digit(word.ch);
    assign c_alnum       = is_alnum(word.ch);
    assign cur_label_err = label_check(label_reg, prev_reg, digits_reg, max_label_length);
    assign cur_name_err  = name_check(label_reg, total_reg, prev_reg, digits_reg,
                                      max_label_length, max_name_length);

    // Character handling by phase, then the end-of-text verdict.
    always_comb
    begin
        t_phase  = phase_reg;
        t_label  = label_reg;
        t_total  = total_reg;
        t_prev   = prev_reg;
        t_digits = digits_reg;
        ignoring = 1'b0;
        give     = 1'b0;
        stop     = 1'b0;
        err      = ERR_NONE;

        case (phase_reg)
            PH_START:
            begin
                if (c_alnum)
                begin
                    t_label  = LABEL_W'(1);
                    t_digits = c_digit;
                    t_prev   = 1'b1;
                    t_total  = total_reg[TOTAL_W-1] ? total_reg : total_reg + 1'b1;
                    t_phase  = PH_LABEL;
                end
                else
                begin
                    give = 1'b1;
                    stop = 1'b1;
                    err  = ERR_BAD_START;
                end
            end
            PH_LABEL:
            begin
                if (c_alnum || (word.ch == CH_HYPHEN))
                begin
                    t_label  = label_reg[LABEL_W-1] ? label_reg : label_reg + 1'b1;
                    t_total  = total_reg[TOTAL_W-1] ? total_reg : total_reg + 1'b1;
                    t_prev   = c_alnum;
                    t_digits = digits_reg && c_digit;
                end
                else if (word.ch == CH_DOT)
                begin
                    if (cur_label_err != ERR_NONE)
                    begin
                        give = 1'b1;
                        stop = 1'b1;
                        err  = cur_label_err;
                    end
                    else
                    begin
                        t_total  = total_reg[TOTAL_W-1] ? total_reg : total_reg + 1'b1;
                        t_phase  = PH_START;
                        t_label  = '0;
                        t_prev   = 1'b0;
                        t_digits = 1'b1;
                    end
                end
                else
                begin
                    give = 1'b1;
                    stop = 1'b1;
                    err  = cur_name_err;
                end
            end
            default:
            begin
                ignoring = 1'b1;
            end
        endcase

        // End of text with no verdict yet: judge the updated state.
        if (!ignoring && !give && word.last)
        begin
            give = 1'b1;
            stop = 1'b0;
            if (t_phase == PH_START)
            begin
                err = ERR_BAD_START;
            end
            else
            begin
                err = name_check(t_label, t_total, t_prev, t_digits,
                                 max_label_length, max_name_length);
            end
        end
    end

    // Commit: the last word clears the scanner, a verdict moves to ignoring.
    always_comb
    begin
        phase_next  = t_phase;
        label_next  = t_label;
        total_next  = t_total;
        prev_next   = t_prev;
        digits_next = t_digits;
        if ((ignoring || give) && word.last)
        begin
            phase_next  = PH_START;
            label_next  = '0;
            total_next  = '0;
            prev_next   = 1'b0;
            digits_next = 1'b1;
        end
        else if (ignoring || give)
        begin
            phase_next = PH_IGNORE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            label_reg  <= '0;
            total_reg  <= '0;
            prev_reg   <= 1'b0;
            digits_reg <= 1'b1;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            label_reg  <= label_next;
            total_reg  <= total_next;
            prev_reg   <= prev_next;
            digits_reg <= digits_next;
        end
    end

    // Verdict fields; the length is reported only for an accepted name.
    assign verdict.valid           = give;
    assign verdict.ok              = (err == ERR_NONE);
    assign verdict.fail_code       = err;
    assign verdict.name_length     = (err == ERR_NONE) ? t_total[7:0] : 8'd0;
    assign verdict.stopped_at_char = stop;

    `HV_ASSERT_IMPLY(a_start_empty_label, clk, rst_n, phase_reg == PH_START, label_reg == '0)
    `HV_ASSERT_IMPLY(a_label_nonempty, clk, rst_n, phase_reg == PH_LABEL, label_reg != '0)
    `HV_ASSERT_IMPLY(a_total_covers_label, clk, rst_n, phase_reg == PH_LABEL,
                     total_reg >= TOTAL_W'(label_reg))

endmodule

`default_nettype wire

/* rtl/core/hostname_validator.sv */
// Top level of the streaming hostname validator.
//
//   Channel   Signals                                            Direction
//   input     in_valid, in_ready, ch, last                       in
//   output    out_valid, out_ready, ok, fail_code,               out
//             name_length, stopped_at_char
//   config    psel, penable, pwrite, paddr, pwdata, prdata, pready  APB slave
//
// One word is accepted every cycle unless the result register is stalled; a
// verdict passes from the input register through the scanner into the result
// register. The scanner state update is combinational, which sets the rate.
// Reset clears the scanner and the pipeline and loads limits 63 and 255.
// When the result register is full and not taken, the input register and the
// scanner hold, and in_ready drops in the same cycle if a word is held.
`default_nettype none
`include "hostname_validator_macros.svh"

module hostname_validator
    import hv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        ok,
    output logic [2:0]  fail_code,
    output logic [7:0]  name_length,
    output logic        stopped_at_char,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       s1_valid_reg, s1_valid_next;
    char_word_t s1_word_reg;
    logic       out_valid_reg, out_valid_next;
    verdict_t   out_reg;
    verdict_t   scan_verdict;
    logic       in_take;
    logic       scan_step;
    logic [5:0] max_label_length;
    logic [7:0] max_name_length;

    hv_cfg_regs u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .max_label_length (max_label_length),
        .max_name_length  (max_name_length)
    );

    hv_scan u_scan (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (scan_step),
        .word             (s1_word_reg),
        .max_label_length (max_label_length),
        .max_name_length  (max_name_length),
        .verdict          (scan_verdict)
    );

    // The scanner advances whenever a word is held and the result register can take a verdict.
    assign scan_step = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || scan_step;
    assign in_take   = in_valid && in_ready;

    // Input register.
    always_comb
    begin
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (scan_step)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_word_reg.ch   <= ch;
            s1_word_reg.last <= last;
        end
    end

    // Result register.
    always_comb
    begin
        if (scan_step && scan_verdict.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_step && scan_verdict.valid)
        begin
            out_reg <= scan_verdict;
        end
    end

    assign out_valid       = out_valid_reg;
    assign ok              = out_reg.ok;
    assign fail_code       = out_reg.fail_code;
    assign name_length     = out_reg.name_length;
    assign stopped_at_char = out_reg.stopped_at_char;

    `HV_ASSERT_IMPLY(a_ok_matches_code, clk, rst_n, out_valid_reg,
                     ok == (fail_code == ERR_NONE))
    `HV_ASSERT_IMPLY(a_fail_zero_length, clk, rst_n, out_valid_reg && !ok, name_length == 8'd0)
    `HV_ASSERT_NEXT(a_take_fills_stage, clk, rst_n, in_take, s1_valid_reg)

endmodule

`default_nettype wire
